// ----- design/suc_pkg.sv -----
// ----------------------------------------------------------------------------
// suc_pkg
// shared types and constants of the sample upload cache: table geometry,
// field widths, result status codes, controller states and entry layout
// ----------------------------------------------------------------------------
package suc_pkg;

  localparam int unsigned TableEntries = 16;
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW = $clog2(TableEntries + 1);

  localparam int unsigned KeyW  = 32;
  localparam int unsigned LenW  = 16;
  localparam int unsigned NeedW = LenW + 1;
  localparam int unsigned AddrW = 20;
  localparam int unsigned OffW  = 19;
  localparam int unsigned EntW  = 5;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [AddrW-1:0] SpanStartRst = 20'h00000;
  localparam logic [AddrW-1:0] SpanEndRst   = 20'h80000;

  localparam logic [CfgIdxW-1:0] CfgSpanStart = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSpanEnd   = 2'd1;

  typedef enum logic [2:0] {
    StatHit        = 3'd0,
    StatMiss       = 3'd1,
    StatMissFlush  = 3'd2,
    StatTooBig     = 3'd3,
    StatFlushed    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    StIdle,
    StEval,
    StSearch,
    StAlloc,
    StDone
  } state_e;

  typedef struct packed {
    logic [OffW-1:0] offset;
    logic [LenW-1:0] loop_length;
    logic [LenW-1:0] body_length;
    logic [KeyW-1:0] sample_key;
  } entry_t;

  typedef struct packed {
    logic            en;
    logic [IdxW-1:0] addr;
    entry_t          entry;
  } tbl_wr_t;

  // packed so that status sits in the lowest bits
  typedef struct packed {
    logic [EntW-1:0]  entries_in_use;
    logic [AddrW-1:0] bytes_in_use;
    logic [OffW-1:0]  ram_offset;
    status_e          status;
  } result_t;

endpackage

// ----- design/sample_upload_cache_top.sv -----
// ----------------------------------------------------------------------------
// sample_upload_cache_top
// sample upload cache: bump allocator over a sound-ram span with a table of
// uploaded samples searched one entry per cycle
// ----------------------------------------------------------------------------
// sequence: a flush or too-big beat is evaluated and goes straight to done; an
// acquire is evaluated, scans a non-empty table from entry 0 until a hit or the
// fill count, allocates on a miss, then waits in done for the output register
// throughput: one item at a time; a new beat is taken only back in the idle state
// reset: span 0 to 0x80000, cursor at span start, table empty; table memory
// is not cleared, entries past the fill count are never used for a match
module sample_upload_cache_top import suc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [63:0]        s_axis_tdata,   // sample_key, body_length, loop_length
  input  logic               s_axis_tuser,   // kind
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [47:0]        m_axis_tdata,   // status, ram_offset, bytes_in_use,
                                             // entries_in_use, zero pad
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [AddrW-1:0]   cfg_data_i
);

  state_e           state_q, state_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [AddrW-1:0] start_q, end_q;
  logic [AddrW-1:0] cursor_q, cursor_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             kind_q;
  logic [KeyW-1:0]  key_q;
  logic [LenW-1:0]  blen_q, llen_q;
  logic [NeedW-1:0] need_q, need_d;
  result_t          res_q, res_d;
  logic             res_ld;
  result_t          out_q;
  logic             out_vld_q, out_ld;

  logic             s_acc, cfg_acc;
  tbl_wr_t          tbl_wr;
  logic [IdxW-1:0]  rd_addr;
  entry_t           rd_entry;
  logic             match;

  logic [AddrW-1:0] span;
  logic             too_big;
  logic [AddrW:0]   end_sum;
  logic             full;
  logic [AddrW-1:0] base;
  logic [CntW-1:0]  idx_plus;

  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StIdle);
  assign cfg_ready_o   = 1'b1;
  assign cfg_acc       = cfg_valid_i && cfg_ready_o &&
                         (cfg_index_i == CfgSpanStart || cfg_index_i == CfgSpanEnd);

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_q};

  // round the sum of both lengths up to an even size
  assign need_d = (NeedW'(s_axis_tdata[47:32]) + NeedW'(s_axis_tdata[63:48]) +
                   NeedW'(1)) & ~NeedW'(1);

  assign span     = (end_q >= start_q) ? (end_q - start_q) : '0;
  assign too_big  = (need_q == '0) || (AddrW'(need_q) > span);
  assign end_sum  = {1'b0, cursor_q} + (AddrW + 1)'(need_q);
  assign full     = (end_sum > {1'b0, end_q}) || (count_q >= CntW'(TableEntries));
  assign base     = full ? start_q : cursor_q;
  assign idx_plus = idx_q + CntW'(1);

  suc_table u_table (
    .clk_i         (clk_i),
    .wr_i          (tbl_wr),
    .rd_addr_i     (rd_addr),
    .key_i         (key_q),
    .body_length_i (blen_q),
    .loop_length_i (llen_q),
    .rd_entry_o    (rd_entry),
    .match_o       (match)
  );

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    cursor_d = cursor_q;
    count_d  = count_q;
    res_ld   = 1'b0;
    out_ld   = 1'b0;
    rd_addr  = '0;
    tbl_wr.en                = 1'b0;
    tbl_wr.addr              = count_q[IdxW-1:0];
    tbl_wr.entry.sample_key  = key_q;
    tbl_wr.entry.body_length = blen_q;
    tbl_wr.entry.loop_length = llen_q;
    tbl_wr.entry.offset      = base[OffW-1:0];
    res_d.status         = StatTooBig;
    res_d.ram_offset     = '0;
    res_d.bytes_in_use   = cursor_q - start_q;
    res_d.entries_in_use = EntW'(count_q);

    unique case (state_q)
      StIdle: begin
        if (s_acc) begin
          state_d = StEval;
        end
      end
      StEval: begin
        idx_d = '0;
        if (kind_q) begin
          cursor_d             = start_q;
          count_d              = '0;
          res_d.status         = StatFlushed;
          res_d.bytes_in_use   = '0;
          res_d.entries_in_use = '0;
          res_ld               = 1'b1;
          state_d              = StDone;
        end else if (too_big) begin
          res_ld  = 1'b1;
          state_d = StDone;
        end else if (count_q == '0) begin
          state_d = StAlloc;
        end else begin
          state_d = StSearch;
        end
      end
      StSearch: begin
        rd_addr = idx_plus[IdxW-1:0];
        if (match) begin
          res_d.status     = StatHit;
          res_d.ram_offset = rd_entry.offset;
          res_ld           = 1'b1;
          state_d          = StDone;
        end else if (idx_plus == count_q) begin
          state_d = StAlloc;
        end else begin
          idx_d = idx_plus;
        end
      end
      StAlloc: begin
        tbl_wr.en   = 1'b1;
        tbl_wr.addr = full ? '0 : count_q[IdxW-1:0];
        cursor_d    = base + AddrW'(need_q);
        count_d     = full ? CntW'(1) : count_q + CntW'(1);
        res_d.status         = full ? StatMissFlush : StatMiss;
        res_d.ram_offset     = base[OffW-1:0];
        res_d.bytes_in_use   = cursor_d - start_q;
        res_d.entries_in_use = EntW'(count_d);
        res_ld               = 1'b1;
        state_d              = StDone;
      end
      StDone: begin
        if (!out_vld_q || m_axis_tready) begin
          out_ld  = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // writes to the span registers flush the table
    if (cfg_acc) begin
      cursor_d = (cfg_index_i == CfgSpanStart) ? cfg_data_i : start_q;
      count_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      idx_q     <= '0;
      start_q   <= SpanStartRst;
      end_q     <= SpanEndRst;
      cursor_q  <= SpanStartRst;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      cursor_q <= cursor_d;
      count_q  <= count_d;
      if (cfg_acc && cfg_index_i == CfgSpanStart) begin
        start_q <= cfg_data_i;
      end
      if (cfg_acc && cfg_index_i == CfgSpanEnd) begin
        end_q <= cfg_data_i;
      end
      if (out_ld) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      kind_q <= s_axis_tuser;
      key_q  <= s_axis_tdata[31:0];
      blen_q <= s_axis_tdata[47:32];
      llen_q <= s_axis_tdata[63:48];
      need_q <= need_d;
    end
    if (res_ld) begin
      res_q <= res_d;
    end
    if (out_ld) begin
      out_q <= res_q;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableEntries))
    else $error("entry count above table size");

  a_empty_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (cursor_q == start_q))
    else $error("empty table with cursor off span start");

  a_cursor_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q >= start_q)
    else $error("cursor below span start");

  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> (state_q == StEval && !s_axis_tready))
    else $error("input beat not followed by evaluation");

endmodule

// ----- design/suc_table.sv -----
// ----------------------------------------------------------------------------
// suc_table
// entry memory of the sample upload cache: one write port, one read port
// with registered data, and the match of key and both lengths against the registered entry
// ----------------------------------------------------------------------------
module suc_table import suc_pkg::*; (
  input  logic            clk_i,
  input  tbl_wr_t         wr_i,
  input  logic [IdxW-1:0] rd_addr_i,
  input  logic [KeyW-1:0] key_i,
  input  logic [LenW-1:0] body_length_i,
  input  logic [LenW-1:0] loop_length_i,
  output entry_t          rd_entry_o,
  output logic            match_o
);

  entry_t mem [TableEntries];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.entry;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr_i];
  end

  assign rd_entry_o = rd_q;
  assign match_o = (rd_q.sample_key == key_i) &&
                   (rd_q.body_length == body_length_i) &&
                   (rd_q.loop_length == loop_length_i);

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sample upload cache: acquire and flush beats go
// in on the stream slave side, every accepted beat is run through a local
// model of the sample table and bump allocator, and each result beat is
// compared field by field against the oldest predicted result
// ----------------------------------------------------------------------------
module tb;
  import suc_pkg::*;

  localparam int CycleLimit     = 400000;
  localparam int LongHoldCycles = 400;
  localparam int PoolSize       = 20;
  localparam int TailCycles     = 30;

  localparam bit KindAcquire = 1'b0;
  localparam bit KindFlush   = 1'b1;

  localparam logic [CfgIdxW-1:0] CfgSpare0 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpare1 = 2'd3;

  typedef struct packed {
    status_e          status;
    logic [OffW-1:0]  offset;
    logic [AddrW-1:0] bytes;
    logic [EntW-1:0]  entries;
  } upload_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [63:0]        s_axis_tdata;   // sample_key, body_length, loop_length
  logic               s_axis_tuser;   // kind
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [47:0]        m_axis_tdata;   // status, ram_offset, bytes_in_use,
                                      // entries_in_use, zero pad
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [AddrW-1:0]   cfg_data_i;

  // local copy of the cache state
  logic [AddrW-1:0] span_start_q;
  logic [AddrW-1:0] span_end_q;
  logic [AddrW-1:0] cursor_q;
  logic [EntW-1:0]  fill_q;
  logic [KeyW-1:0]  tbl_key  [TableEntries];
  logic [LenW-1:0]  tbl_blen [TableEntries];
  logic [LenW-1:0]  tbl_llen [TableEntries];
  logic [OffW-1:0]  tbl_off  [TableEntries];

  upload_result_t pending_results[$];

  logic [KeyW-1:0] pool_key  [PoolSize];
  logic [LenW-1:0] pool_blen [PoolSize];
  logic [LenW-1:0] pool_llen [PoolSize];

  bit tx_gaps;
  bit rx_gaps;
  bit long_hold_req;
  int cycle_count;
  int mismatches;
  int items_sent;
  int results_seen;
  int cfg_writes;
  int status_tally[5];

  result_t        seen_result;
  upload_result_t want_result;

  sample_upload_cache_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("** sample_upload_cache_top: FAILED **");
      $finish;
    end
  end

  function automatic void clear_table();
    cursor_q = span_start_q;
    fill_q   = '0;
  endfunction

  function automatic upload_result_t cache_lookup(bit kind, logic [KeyW-1:0] key,
                                                  logic [LenW-1:0] blen,
                                                  logic [LenW-1:0] llen);
    upload_result_t res;
    logic [31:0]    need;
    logic [31:0]    span;
    logic [OffW-1:0] offset;
    bit             wiped;
    wiped = 1'b0;
    if (kind == KindFlush) begin
      clear_table();
      res = '{StatFlushed, '0, '0, '0};
      return res;
    end
    need = (32'(blen) + 32'(llen) + 32'd1) & ~32'd1;
    span = (span_end_q >= span_start_q) ? 32'(span_end_q - span_start_q) : 32'd0;
    if (need == 0 || need > span) begin
      res = '{StatTooBig, '0, cursor_q - span_start_q, fill_q};
      return res;
    end
    for (int i = 0; i < int'(fill_q) && i < TableEntries; i++) begin
      if (tbl_key[i] == key && tbl_blen[i] == blen && tbl_llen[i] == llen) begin
        res = '{StatHit, tbl_off[i], cursor_q - span_start_q, fill_q};
        return res;
      end
    end
    if (32'(cursor_q) + need > 32'(span_end_q) || int'(fill_q) >= TableEntries) begin
      clear_table();
      wiped = 1'b1;
    end
    offset                       = cursor_q[OffW-1:0];
    tbl_key[fill_q[IdxW-1:0]]    = key;
    tbl_blen[fill_q[IdxW-1:0]]   = blen;
    tbl_llen[fill_q[IdxW-1:0]]   = llen;
    tbl_off[fill_q[IdxW-1:0]]    = offset;
    fill_q                       = fill_q + EntW'(1);
    cursor_q                     = AddrW'(32'(cursor_q) + need);
    res = '{wiped ? StatMissFlush : StatMiss, offset, cursor_q - span_start_q, fill_q};
    return res;
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatches < 10) begin
      $display("[%0d] mismatch: %s", cycle_count, what);
    end
    mismatches++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_result = result_t'(m_axis_tdata[46:0]);
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result beat %h", m_axis_tdata));
      end else begin
        want_result = pending_results.pop_front();
        if (int'(want_result.status) < 5) status_tally[int'(want_result.status)]++;
        if (seen_result.status !== want_result.status ||
            seen_result.ram_offset !== want_result.offset ||
            seen_result.bytes_in_use !== want_result.bytes ||
            seen_result.entries_in_use !== want_result.entries ||
            m_axis_tdata[47] !== 1'b0) begin
          flag_mismatch($sformatf(
            "exp status %0d off %h bytes %h ent %0d / got status %0d off %h bytes %h ent %0d pad %b",
            want_result.status, want_result.offset, want_result.bytes, want_result.entries,
            seen_result.status, seen_result.ram_offset, seen_result.bytes_in_use,
            seen_result.entries_in_use, m_axis_tdata[47]));
        end
      end
    end
  end

  // result sink with random stalls and one long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic push_upload_item(input bit kind, input logic [KeyW-1:0] key,
                                  input logic [LenW-1:0] blen,
                                  input logic [LenW-1:0] llen);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {llen, blen, key};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(cache_lookup(kind, key, blen, llen));
    items_sent++;
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic write_span_reg(input logic [CfgIdxW-1:0] idx,
                                input logic [AddrW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
    if (idx == CfgSpanStart) begin
      span_start_q = value;
      clear_table();
    end else if (idx == CfgSpanEnd) begin
      span_end_q = value;
      clear_table();
    end
  endtask

  task automatic set_span(input logic [AddrW-1:0] first, input logic [AddrW-1:0] past);
    wait_results_drained();
    write_span_reg(CfgSpanStart, first);
    write_span_reg(CfgSpanEnd, past);
  endtask

  task automatic test_basics();
    push_upload_item(KindAcquire, 32'h0000_0000, 16'h0000, 16'h0000);
    push_upload_item(KindAcquire, 32'h0000_0000, 16'hFFFF, 16'hFFFF);
    push_upload_item(KindAcquire, 32'h0000_0000, 16'hFFFF, 16'hFFFF);
    push_upload_item(KindAcquire, 32'hFFFF_FFFF, 16'h0001, 16'h0000);
    push_upload_item(KindFlush, $urandom, 16'($urandom), 16'($urandom));
  endtask

  task automatic test_table_full();
    for (int i = 0; i < TableEntries; i++) begin
      push_upload_item(KindAcquire, 32'h100 + i, 16'(i + 1), 16'h0000);
    end
    push_upload_item(KindAcquire, 32'h100 + TableEntries - 1, 16'(TableEntries), 16'h0000);
    push_upload_item(KindAcquire, 32'hABCD_0000, 16'h0002, 16'h0001);
  endtask

  task automatic test_span_edges();
    logic [KeyW-1:0] key;
    key = $urandom;
    set_span(20'h00100, 20'h00108);
    push_upload_item(KindAcquire, key, 16'h0007, 16'h0000);
    push_upload_item(KindAcquire, key + 1, 16'h0000, 16'h0002);
    push_upload_item(KindAcquire, key + 2, 16'h0005, 16'h0005);
    set_span(20'h80000, 20'h80000);
    push_upload_item(KindAcquire, key, 16'h0001, 16'h0001);
    set_span(20'h00000, 20'h00000);
    push_upload_item(KindAcquire, key, 16'h0001, 16'h0001);
    set_span(20'h80000, 20'h00000);
    push_upload_item(KindAcquire, key, 16'h0001, 16'h0001);
    // writes to unused indexes must leave the table alone
    set_span(20'h01000, 20'h80000);
    push_upload_item(KindAcquire, key, 16'h0123, 16'h0040);
    wait_results_drained();
    write_span_reg(CfgSpare0, 20'($urandom));
    write_span_reg(CfgSpare1, 20'($urandom));
    push_upload_item(KindAcquire, key, 16'h0123, 16'h0040);
  endtask

  task automatic test_output_stall();
    set_span(20'h00000, 20'h02000);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    long_hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      push_upload_item(KindAcquire, 32'(i % 7), 16'($urandom_range(1, 300)) & 16'h00F0,
                       16'(i % 3));
    end
    wait_results_drained();
  endtask

  task automatic test_random_uploads(input logic [AddrW-1:0] first,
                                     input logic [AddrW-1:0] past,
                                     input logic [LenW-1:0] len_mask,
                                     input int count, input bit gaps);
    int pick;
    int slot;
    logic [KeyW-1:0] key;
    logic [LenW-1:0] blen;
    logic [LenW-1:0] llen;
    set_span(first, past);
    for (int i = 0; i < PoolSize; i++) begin
      pool_key[i]  = $urandom;
      pool_blen[i] = 16'($urandom) & len_mask;
      pool_llen[i] = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'($urandom) & len_mask;
    end
    tx_gaps = gaps;
    rx_gaps = gaps;
    for (int n = 0; n < count; n++) begin
      if (gaps && n % 40 == 0) begin
        tx_gaps = ($urandom_range(0, 2) != 0);
        rx_gaps = ($urandom_range(0, 2) != 0);
      end
      pick = $urandom_range(0, 99);
      slot = $urandom_range(0, PoolSize - 1);
      if (pick < 60) begin
        push_upload_item(KindAcquire, pool_key[slot], pool_blen[slot], pool_llen[slot]);
      end else if (pick < 80) begin
        key  = $urandom;
        blen = 16'($urandom) & len_mask;
        llen = 16'($urandom) & len_mask;
        if ($urandom_range(0, 3) == 0) begin
          pool_key[slot]  = key;
          pool_blen[slot] = blen;
          pool_llen[slot] = llen;
        end
        push_upload_item(KindAcquire, key, blen, llen);
      end else if (pick < 87) begin
        push_upload_item(KindAcquire, $urandom, 16'h0000, 16'h0000);
      end else if (pick < 93) begin
        push_upload_item(KindFlush, $urandom, 16'($urandom), 16'($urandom));
      end else begin
        push_upload_item(KindAcquire, $urandom, 16'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    tx_gaps       = 1'b0;
    rx_gaps       = 1'b0;
    long_hold_req = 1'b0;
    cycle_count   = 0;
    mismatches    = 0;
    items_sent    = 0;
    results_seen  = 0;
    cfg_writes    = 0;
    span_start_q  = SpanStartRst;
    span_end_q    = SpanEndRst;
    clear_table();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_basics();
    test_table_full();
    test_span_edges();
    test_output_stall();
    test_random_uploads(20'h00000, 20'h80000, 16'hFFFF, 150, 1'b1);
    test_random_uploads(20'($urandom_range(0, 'h7F000)), 20'h00000, 16'h00FF, 10, 1'b1);
    test_random_uploads(20'h12340, 20'h12740, 16'h00FF, 150, 1'b1);
    test_random_uploads(20'h30000, 20'($urandom_range('h30002, 'h34000)), 16'h0FFF, 150,
                        1'b1);
    test_random_uploads(20'h80000, 20'h10000, 16'h0FFF, 40, 1'b1);
    test_random_uploads(20'h00000, 20'h80000, 16'h03FF, 150, 1'b1);
    test_random_uploads(20'($urandom_range(0, 'h80000)), 20'($urandom_range(0, 'h80000)),
                        16'h7FFF, 150, 1'b1);
    test_random_uploads(20'h7FF00, 20'h80000, 16'h003F, 150, 1'b1);
    test_random_uploads(20'h00000, 20'h80000, 16'h0FFF, 220, 1'b0);
    wait_results_drained();

    $display("sent %0d items, checked %0d results, %0d span register writes",
             items_sent, results_seen, cfg_writes);
    $display("hit %0d, miss %0d, miss after flush %0d, too big %0d, flushed %0d",
             status_tally[StatHit], status_tally[StatMiss], status_tally[StatMissFlush],
             status_tally[StatTooBig], status_tally[StatFlushed]);
    if (mismatches == 0) begin
      $display("** sample_upload_cache_top: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** sample_upload_cache_top: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/suc_pkg.sv
design/suc_table.sv
design/sample_upload_cache_top.sv
tb/tb.sv
